### rtl/core/assert_macros.svh
// assertion helpers shared by the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define NAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define NAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/nau_pkg.sv
`timescale 1ns / 1ps

package nau_pkg;

	// fixed-point format and table geometry
	localparam int FRAC_BITS      = 12;
	localparam int TABLE_SEGMENTS = 32;
	localparam int IN_W           = 16;
	localparam int SLOPE_W        = 13;
	localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
	localparam int POS_BITS       = FRAC_BITS + 3;          // |x| < 8.0 range
	localparam int FRAC_W         = POS_BITS - SEG_BITS;    // interpolation fraction
	localparam int ARG_W          = IN_W + 1;               // room for 2x
	localparam int DIFF_W         = 8;                      // max node step is 255
	localparam int PROD_W         = DIFF_W + FRAC_W;
	localparam int ONE_INT        = 1 << FRAC_BITS;

	localparam logic [SLOPE_W-1:0] ONE = SLOPE_W'(ONE_INT);

	// activation select codes
	typedef enum logic [1:0] {
		KIND_RELU     = 2'd0,
		KIND_SIGMOID  = 2'd1,
		KIND_TANH     = 2'd2,
		KIND_IDENTITY = 2'd3
	} act_kind_t;

	// sigmoid(8*i/TABLE_SEGMENTS) scaled by ONE, rounded
	localparam logic [SLOPE_W-1:0] SIG_NODE [0:TABLE_SEGMENTS] = '{
		13'd2048, 13'd2303, 13'd2550, 13'd2782, 13'd2994, 13'd3184, 13'd3349, 13'd3490,
		13'd3608, 13'd3705, 13'd3785, 13'd3850, 13'd3902, 13'd3943, 13'd3976, 13'd4002,
		13'd4022, 13'd4038, 13'd4051, 13'd4061, 13'd4069, 13'd4075, 13'd4079, 13'd4083,
		13'd4086, 13'd4088, 13'd4090, 13'd4091, 13'd4092, 13'd4093, 13'd4094, 13'd4094,
		13'd4095
	};

	// item leaving the sigmoid interpolator
	typedef struct packed {
		logic                   valid;
		act_kind_t              kind;
		logic signed [IN_W-1:0] x;
		logic                   neg;
		logic [SLOPE_W-1:0]     mag;   // sigmoid of the magnitude
	} nau_sig_t;

endpackage

### rtl/core/nau_sig_interp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nau_sig_interp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  nau_pkg::act_kind_t           kind,
	input  logic signed [nau_pkg::IN_W-1:0] sample,
	output nau_pkg::nau_sig_t            sig_out
);
	import nau_pkg::*;

	logic signed [ARG_W-1:0] arg;
	logic [ARG_W-1:0]        arg_abs;

	logic                    valid_s1;
	act_kind_t               kind_s1;
	logic signed [IN_W-1:0]  x_s1;
	logic                    neg_s1;
	logic                    sat_s1;
	logic [SEG_BITS-1:0]     seg_s1;
	logic [FRAC_W-1:0]       frac_s1;

	logic                    valid_s2;
	act_kind_t               kind_s2;
	logic signed [IN_W-1:0]  x_s2;
	logic                    neg_s2;
	logic                    sat_s2;
	logic [FRAC_W-1:0]       frac_s2;
	logic [SLOPE_W-1:0]      lo_s2;
	logic [DIFF_W-1:0]       diff_s2;

	logic [SEG_BITS:0]       seg_hi;
	logic [SLOPE_W-1:0]      node_step;
	logic [PROD_W-1:0]       prod;
	logic [SLOPE_W-1:0]      interp;

	logic                    valid_s3;
	act_kind_t               kind_s3;
	logic signed [IN_W-1:0]  x_s3;
	logic                    neg_s3;
	logic [SLOPE_W-1:0]      mag_s3;

	// table argument: 2x for tanh, magnitude and sign
	always_comb begin
		if (kind == KIND_TANH) begin
			arg = {sample, 1'b0};
		end else begin
			arg = {sample[IN_W-1], sample};
		end
		arg_abs = arg[ARG_W-1] ? ARG_W'(-arg) : arg;
	end

	// stage 1: segment, fraction, saturation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		x_s1    <= sample;
		neg_s1  <= arg[ARG_W-1];
		sat_s1  <= |arg_abs[ARG_W-1:POS_BITS];
		seg_s1  <= arg_abs[POS_BITS-1 -: SEG_BITS];
		frac_s1 <= arg_abs[FRAC_W-1:0];
	end

	// stage 2: node lookup
	assign seg_hi    = {1'b0, seg_s1} + 1'b1;
	assign node_step = SIG_NODE[seg_hi] - SIG_NODE[seg_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		x_s2    <= x_s1;
		neg_s2  <= neg_s1;
		sat_s2  <= sat_s1;
		frac_s2 <= frac_s1;
		lo_s2   <= SIG_NODE[seg_s1];
		diff_s2 <= node_step[DIFF_W-1:0];
	end

	// stage 3: linear interpolation with rounding
	always_comb begin
		prod   = PROD_W'(diff_s2) * PROD_W'(frac_s2);
		interp = lo_s2 + SLOPE_W'((prod + PROD_W'(1 << (FRAC_W - 1))) >> FRAC_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		kind_s3 <= kind_s2;
		x_s3    <= x_s2;
		neg_s3  <= neg_s2;
		mag_s3  <= sat_s2 ? ONE : interp;
	end

	assign sig_out.valid = valid_s3;
	assign sig_out.kind  = kind_s3;
	assign sig_out.x     = x_s3;
	assign sig_out.neg   = neg_s3;
	assign sig_out.mag   = mag_s3;

	// interpolated sigmoid never passes one
	`NAU_ASSERT_IMP(a_mag_range, clk, arst_n, valid_s3, mag_s3 <= ONE)
	// the saturation flag forces exactly one on the next stage
	`NAU_ASSERT_NXT(a_sat_one, clk, arst_n, valid_s2 && sat_s2, mag_s3 == ONE)

endmodule

### rtl/core/nau_deriv.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nau_deriv (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nau_pkg::nau_sig_t                sig_in,
	output logic                             done,
	output logic signed [nau_pkg::IN_W-1:0]  activation,
	output logic [nau_pkg::SLOPE_W-1:0]      slope
);
	import nau_pkg::*;

	localparam int MUL_W = SLOPE_W + 1;
	localparam int MPR_W = 2 * MUL_W;

	logic [SLOPE_W-1:0]       sig_val;
	logic signed [IN_W-1:0]   y_next;

	logic                     valid_s4;
	act_kind_t                kind_s4;
	logic signed [IN_W-1:0]   y_s4;

	logic signed [MUL_W-1:0]  y_n;
	logic signed [MUL_W-1:0]  mul_b;

	logic                     valid_s5;
	act_kind_t                kind_s5;
	logic signed [IN_W-1:0]   y_s5;
	logic signed [MPR_W-1:0]  prod_s5;

	logic signed [MPR_W-1:0]  rnd;
	logic [SLOPE_W-1:0]       slope_next;
	act_kind_t                kind_q;

	// stage 4: symmetry and activation select
	always_comb begin
		sig_val = sig_in.neg ? ONE - sig_in.mag : sig_in.mag;
		case (sig_in.kind)
			KIND_RELU: begin
				y_next = sig_in.x[IN_W-1] ? '0 : sig_in.x;
			end
			KIND_SIGMOID: begin
				y_next = $signed(IN_W'(sig_val));
			end
			KIND_TANH: begin
				y_next = $signed(IN_W'({sig_val, 1'b0})) - $signed(IN_W'(ONE));
			end
			default: begin
				y_next = sig_in.x;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= sig_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		kind_s4 <= sig_in.kind;
		y_s4    <= y_next;
	end

	// stage 5: y*(1-y) for sigmoid, y*y for tanh
	always_comb begin
		y_n = y_s4[MUL_W-1:0];
		if (kind_s4 == KIND_SIGMOID) begin
			mul_b = $signed(MUL_W'(ONE)) - y_n;
		end else begin
			mul_b = y_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		kind_s5 <= kind_s4;
		y_s5    <= y_s4;
		prod_s5 <= y_n * mul_b;
	end

	// output stage: round, scale back, select slope
	always_comb begin
		rnd = (prod_s5 + $signed(MPR_W'(ONE_INT >> 1))) >>> FRAC_BITS;
		case (kind_s5)
			KIND_RELU: begin
				slope_next = (!y_s5[IN_W-1] && (y_s5 != '0)) ? ONE : '0;
			end
			KIND_SIGMOID: begin
				slope_next = rnd[SLOPE_W-1:0];
			end
			KIND_TANH: begin
				slope_next = ONE - rnd[SLOPE_W-1:0];
			end
			default: begin
				slope_next = ONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		activation <= y_s5;
		slope      <= slope_next;
		kind_q     <= kind_s5;
	end

	// derivative never exceeds one
	`NAU_ASSERT_IMP(a_slope_range, clk, arst_n, done, slope <= ONE)
	// relu output is never negative
	`NAU_ASSERT_IMP(a_relu_pos, clk, arst_n, done && (kind_q == KIND_RELU), !activation[IN_W-1])

endmodule

### rtl/core/neural_activation_unit_core.sv
// Neural activation unit: ReLU, sigmoid, tanh or identity on signed Q4.12 samples.
// Configuration: act_kind is written from cfg_wdata at any edge with cfg_we high
//   (0 relu, 1 sigmoid, 2 tanh, 3 identity); change it only while no sample is in flight.
// Input: a sample is transferred at each rising edge with start high and busy low.
//   busy is always low, so one sample can be transferred every cycle.
// Output: each sample gives one result; done is high for exactly one cycle while
//   activation (y, Q4.12 signed) and slope (derivative from y, Q1.12 unsigned) are valid.
// Pipeline: done follows the cycle in which start was taken through the six register
//   stages (argument, node lookup, interpolation, activation select, slope multiply,
//   output register).
// Throughput: one sample per cycle, results in the same order as the samples.
// Sigmoid is a 33-node constant table with linear interpolation; tanh uses the same
//   table at 2x. The receiver cannot stall, so results are never held back.
// Reset: arst_n clears the pipeline valid bits and sets act_kind to relu;
//   no result is produced for samples in flight at reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module neural_activation_unit_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_wdata,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [nau_pkg::IN_W-1:0]  sample,
	output logic                             done,
	output logic signed [nau_pkg::IN_W-1:0]  activation,
	output logic [nau_pkg::SLOPE_W-1:0]      slope
);
	import nau_pkg::*;

	act_kind_t act_kind_q;
	nau_sig_t  sig_item;
	logic      accept;

	// fully pipelined, never back-pressures the sender
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_kind_q <= KIND_RELU;
		end else if (cfg_we) begin
			act_kind_q <= act_kind_t'(cfg_wdata);
		end
	end

	// sigmoid interpolation pipeline
	nau_sig_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.kind     (act_kind_q),
		.sample   (sample),
		.sig_out  (sig_item)
	);

	// activation and derivative pipeline
	nau_deriv u_deriv (
		.clk        (clk),
		.arst_n     (arst_n),
		.sig_in     (sig_item),
		.done       (done),
		.activation (activation),
		.slope      (slope)
	);

	// every result traces back to an earlier transfer
	`NAU_ASSERT_IMP(a_done_latency, clk, arst_n, done, $past(start, 6))
	// every item leaving the interpolator traces back to an accepted transfer
	`NAU_ASSERT_IMP(a_interp_latency, clk, arst_n, sig_item.valid, $past(accept, 3))

endmodule
